// ===== src/ltc_pkg.sv =====
package ltc_pkg;

	localparam int ENTRIES_DEF   = 32;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int TRACK_KEY_W   = 32;
	localparam int TICK_W        = 32;
	localparam int IDX_OUT_W     = 5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} ltc_state_t;

	// controller -> datapath
	typedef struct packed {
		logic start;   // latch request, clear scan state
		logic scan;    // issue next entry read
		logic commit;  // write back entry, load result
	} ltc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;        // match found
		logic last_cmp;   // last entry compared this cycle
		logic slot_free;  // result register can take a new transaction
	} ltc_status_t;

	typedef struct packed {
		logic                 hit;
		logic [IDX_OUT_W-1:0] entry_index;
		logic                 entry_returned;
		logic                 victim_was_valid;
	} ltc_res_t;

endpackage

// ===== src/ltc_req_if.sv =====
interface ltc_req_if;
	import ltc_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [TRACK_KEY_W-1:0] track_key;
	logic [TICK_W-1:0]      now_tick;
	logic                   fill_ok;

	modport source (output valid, output track_key, output now_tick, output fill_ok,
		input ready);
	modport sink (input valid, input track_key, input now_tick, input fill_ok,
		output ready);
endinterface

// ===== src/ltc_rsp_if.sv =====
interface ltc_rsp_if;
	import ltc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [IDX_OUT_W-1:0] entry_index;
	logic                 entry_returned;
	logic                 victim_was_valid;

	modport source (output valid, output hit, output entry_index, output entry_returned,
		output victim_was_valid, input ready);
	modport sink (input valid, input hit, input entry_index, input entry_returned,
		input victim_was_valid, output ready);
endinterface

// ===== src/ltc_ctrl.sv =====
module ltc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ltc_pkg::ltc_status_t status,
	output ltc_pkg::ltc_cmd_t    cmd
);
	import ltc_pkg::*;

	ltc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.hit || status.last_cmp) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (status.slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/ltc_datapath.sv =====
module ltc_datapath #(
	parameter int ENTRIES   = ltc_pkg::ENTRIES_DEF,
	parameter int KEY_WIDTH = ltc_pkg::KEY_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ltc_pkg::ltc_cmd_t               cmd,
	output ltc_pkg::ltc_status_t            status,
	input  logic [ltc_pkg::TRACK_KEY_W-1:0] in_key,
	input  logic [ltc_pkg::TICK_W-1:0]      in_tick,
	input  logic                            in_fill,
	input  logic                            out_ready,
	output logic                            res_valid,
	output ltc_pkg::ltc_res_t               res
);
	import ltc_pkg::*;

	localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int XW   = (IW > IDX_OUT_W) ? IW : IDX_OUT_W;
	localparam int KXW  = (KEY_WIDTH > TRACK_KEY_W) ? KEY_WIDTH : TRACK_KEY_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	// tag and stamp stores
	logic [KEY_WIDTH-1:0] key_mem   [ENTRIES];
	logic [TICK_W-1:0]    stamp_mem [ENTRIES];
	logic [ENTRIES-1:0]   valid_q;

	// request
	logic [KEY_WIDTH-1:0] key_q;
	logic [TICK_W-1:0]    tick_q;
	logic                 fill_q;
	logic [KXW-1:0]       key_ext;

	// scan
	logic [CW-1:0]        cnt_q;
	logic [IW-1:0]        rd_idx;
	logic                 issue;
	logic                 cmp_vld_s1;
	logic [IW-1:0]        cmp_idx_s1;
	logic                 valid_s1;
	logic [KEY_WIDTH-1:0] key_s1;
	logic [TICK_W-1:0]    stamp_s1;

	logic                 hit_q;
	logic [IW-1:0]        hit_idx_q;
	logic                 found_free_q;
	logic [IW-1:0]        free_idx_q;
	logic [TICK_W-1:0]    min_stamp_q;
	logic [IW-1:0]        min_idx_q;

	logic                 key_match;
	logic                 take_min;
	logic [IW-1:0]        victim;
	logic [XW-1:0]        victim_ext;

	logic                 res_vld_q;
	ltc_res_t             res_q;

	assign key_ext    = KXW'(in_key);
	assign rd_idx     = cnt_q[IW-1:0];
	assign issue      = cmd.scan && (cnt_q < CW'(ENTRIES));
	assign key_match  = cmp_vld_s1 && valid_s1 && (key_s1 == key_q);
	assign take_min   = cmp_vld_s1 && ((cmp_idx_s1 == '0) || (stamp_s1 < min_stamp_q));
	assign victim     = hit_q ? hit_idx_q : (found_free_q ? free_idx_q : min_idx_q);
	assign victim_ext = XW'(victim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			cmp_vld_s1   <= 1'b0;
			hit_q        <= 1'b0;
			found_free_q <= 1'b0;
			valid_q      <= '0;
			res_vld_q    <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			if (cmd.start) begin
				cnt_q        <= '0;
				hit_q        <= 1'b0;
				found_free_q <= 1'b0;
			end else begin
				if (issue) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (key_match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (cmp_vld_s1 && !valid_s1 && !found_free_q) begin
					found_free_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				valid_q[victim] <= hit_q || fill_q;
			end
			if (cmd.commit) begin
				res_vld_q <= 1'b1;
			end else if (out_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q  <= key_ext[KEY_WIDTH-1:0];
			tick_q <= in_tick;
			fill_q <= in_fill;
		end
		cmp_idx_s1 <= rd_idx;
		valid_s1   <= valid_q[rd_idx];
		if (key_match && !hit_q) begin
			hit_idx_q <= cmp_idx_s1;
		end
		if (cmp_vld_s1 && !valid_s1 && !found_free_q) begin
			free_idx_q <= cmp_idx_s1;
		end
		if (take_min) begin
			min_stamp_q <= stamp_s1;
			min_idx_q   <= cmp_idx_s1;
		end
		if (cmd.commit) begin
			res_q.hit              <= hit_q;
			res_q.entry_index      <= victim_ext[IDX_OUT_W-1:0];
			res_q.entry_returned   <= hit_q || fill_q;
			res_q.victim_was_valid <= !hit_q && !found_free_q;
		end
	end

	// store ports: one registered read, one write
	always_ff @(posedge clk) begin
		key_s1   <= key_mem[rd_idx];
		stamp_s1 <= stamp_mem[rd_idx];
		if (cmd.commit && (hit_q || fill_q)) begin
			stamp_mem[victim] <= tick_q;
		end
		if (cmd.commit && !hit_q && fill_q) begin
			key_mem[victim] <= key_q;
		end
	end

	assign status.hit       = hit_q;
	assign status.last_cmp  = cmp_vld_s1 && (cmp_idx_s1 == LAST_IDX);
	assign status.slot_free = !res_vld_q || out_ready;

	assign res_valid = res_vld_q;
	assign res       = res_q;

endmodule

// ===== src/lru_tag_cache_lookup.sv =====
// A lookup scans one entry per cycle through the single read port of the
// tag/stamp store, and a hit ends the scan early; the result is then written back and
// registered. One transaction is in flight at a time: a new request is taken only
// after the previous one has been written back.
// Reset: arst_n clears all valid bits and the controller; tags and stamps are not cleared.
module lru_tag_cache_lookup #(
	parameter int ENTRIES   = ltc_pkg::ENTRIES_DEF,
	parameter int KEY_WIDTH = ltc_pkg::KEY_WIDTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	ltc_req_if.sink  req,
	ltc_rsp_if.source rsp
);
	import ltc_pkg::*;

	ltc_cmd_t    cmd;
	ltc_status_t status;
	ltc_res_t    res;
	logic        res_valid;

	// Controller: idle -> scan entries until a hit or the last entry -> write back + load result.
	ltc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: stores, scan compare (hit, first free, oldest stamp), result register.
	// The result register decouples the response side; commit waits while it is full.
	ltc_datapath #(
		.ENTRIES   (ENTRIES),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_key    (req.track_key),
		.in_tick   (req.now_tick),
		.in_fill   (req.fill_ok),
		.out_ready (rsp.ready),
		.res_valid (res_valid),
		.res       (res)
	);

	assign rsp.valid            = res_valid;
	assign rsp.hit              = res.hit;
	assign rsp.entry_index      = res.entry_index;
	assign rsp.entry_returned   = res.entry_returned;
	assign rsp.victim_was_valid = res.victim_was_valid;

	// A hit always returns the entry and never evicts.
	a_hit_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.hit |-> rsp.entry_returned && !rsp.victim_was_valid)
		else $error("hit transaction with bad result flags");

	// Only one request in flight: after acceptance the request side closes.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while a lookup is running");

	// Write back never overruns a result still waiting on the response side.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !rsp.valid || rsp.ready)
		else $error("result register overwritten");

endmodule
